FILE: rtl/core/xxh_pkg.sv
package xxh_pkg;

  localparam logic [63:0] PRIME1 = 64'h9E3779B185EBCA87;
  localparam logic [63:0] PRIME2 = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] PRIME3 = 64'h165667B19E3779F9;
  localparam logic [63:0] PRIME4 = 64'h85EBCA77C2B2AE63;
  localparam logic [63:0] PRIME5 = 64'h27D4EB2F165667C5;

  localparam int unsigned BUF_BYTES = 40;
  localparam int unsigned STRIPE_BYTES = 32;

  typedef enum logic [4:0] {
    OP_ROUND_A,
    OP_ROUND_B,
    OP_STRIPE_SHIFT,
    OP_FIN_INIT,
    OP_MERGE_A,
    OP_MERGE_B,
    OP_MERGE_C,
    OP_ADD_LEN,
    OP_T8_A,
    OP_T8_B,
    OP_T8_C,
    OP_T4_A,
    OP_T4_B,
    OP_T1_A,
    OP_T1_B,
    OP_AV_A,
    OP_AV_B
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] lane;
    logic       load;
    logic       mul_start;
    logic       wb;
    logic       exec;
    logic       emit;
  } dp_cmd_t;

  typedef struct packed {
    logic stripe_full;
    logic long_msg;
    logic fill_ge8;
    logic fill_ge4;
    logic fill_nz;
    logic mul_done;
    logic out_free;
  } dp_status_t;

  function automatic logic [63:0] rotl64(input logic [63:0] x, input logic [5:0] r);
    rotl64 = (x << r) | (x >> (7'd64 - {1'b0, r}));
  endfunction

endpackage

FILE: rtl/core/xxhash64_stream_hasher_unit.sv
// channel   direction  handshake            payload
// in_       input      in_valid / in_stall   in_data_word, in_byte_count, in_last_word
// out_      output     out_valid / out_stall out_hash_value
// cfg_      input      cfg_wr_en             cfg_hash_seed
//
// a word that fills a stripe also runs one round per lane, then a stripe shift
// each 64-bit product is built on one shared 32x32 multiplier
// last word: lane merge (long message only), then 8-byte, 4-byte and 1-byte
// tail steps, avalanche and emit, plus any wait on out_stall
// rst_n clears control state and the seed register, no clearing pass
// result waits in an output register; next word is accepted while it is stalled
module xxhash64_stream_hasher_unit
  import xxh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [63:0] cfg_hash_seed,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_byte_count,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_hash_value
);

  dp_cmd_t    cmd;
  dp_status_t status;

  xxh_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_word (in_last_word),
    .in_stall     (in_stall),
    .status       (status),
    .cmd          (cmd)
  );

  xxh_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_hash_seed  (cfg_hash_seed),
    .in_data_word   (in_data_word),
    .in_byte_count  (in_byte_count),
    .cmd            (cmd),
    .status         (status),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_hash_value (out_hash_value)
  );

endmodule

FILE: rtl/core/xxh_mul.sv
module xxh_mul
  import xxh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] p
);

  logic [63:0] a_r, a_nxt;
  logic [63:0] b_r, b_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [31:0] mx_a, mx_b;
  logic [63:0] pp;

  always_comb begin
    unique case (cnt_r)
      2'd0: begin
        mx_a = a_r[31:0];
        mx_b = b_r[31:0];
      end
      2'd1: begin
        mx_a = a_r[31:0];
        mx_b = b_r[63:32];
      end
      default: begin
        mx_a = a_r[63:32];
        mx_b = b_r[31:0];
      end
    endcase
  end

  assign pp = 64'(mx_a) * 64'(mx_b);

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = a;
      b_nxt    = b;
      cnt_nxt  = 2'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cnt_r == 2'd0) begin
        acc_nxt = pp;
      end else begin
        acc_nxt = acc_r + {pp[31:0], 32'd0};
      end
      if (cnt_r == 2'd2) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
      cnt_nxt = cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    if (!rst_n) begin
      cnt_r  <= 2'd0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

FILE: rtl/core/xxh_datapath.sv
module xxh_datapath
  import xxh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [63:0] cfg_hash_seed,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_byte_count,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [63:0] out_hash_value
);

  logic [63:0]            seed_cfg_r, seed_cfg_nxt;
  logic [63:0]            seed_r, seed_nxt;
  logic [63:0]            lane_r [4];
  logic [63:0]            lane_nxt [4];
  logic [BUF_BYTES*8-1:0] buf_r, buf_nxt;
  logic [5:0]             fill_r, fill_nxt;
  logic [63:0]            len_r, len_nxt;
  logic                   open_r, open_nxt;
  logic [63:0]            h_r, h_nxt;
  logic [63:0]            t_r, t_nxt;
  logic [63:0]            hash_r, hash_nxt;
  logic                   valid_r, valid_nxt;

  logic [3:0]  cnt_sat;
  logic [5:0]  base_fill;
  logic [63:0] base_len;
  logic [5:0]  idx;
  logic [63:0] lane_sel;
  logic [63:0] word_sel;
  logic [63:0] conv;
  logic [63:0] mul_a, mul_b, mul_p;
  logic        mul_done;

  assign cnt_sat   = (in_byte_count > 4'd8) ? 4'd8 : in_byte_count;
  assign base_fill = open_r ? fill_r : 6'd0;
  assign base_len  = open_r ? len_r : 64'd0;
  assign lane_sel  = lane_r[cmd.lane];
  assign word_sel  = buf_r[{cmd.lane, 6'd0} +: 64];
  assign conv      = rotl64(lane_r[0], 6'd1) + rotl64(lane_r[1], 6'd7)
                   + rotl64(lane_r[2], 6'd12) + rotl64(lane_r[3], 6'd18);

  always_comb begin
    unique case (cmd.op)
      OP_ROUND_A: begin mul_a = word_sel;                        mul_b = PRIME2; end
      OP_ROUND_B: begin mul_a = rotl64(lane_sel + t_r, 6'd31);   mul_b = PRIME1; end
      OP_MERGE_A: begin mul_a = lane_sel;                        mul_b = PRIME2; end
      OP_MERGE_B: begin mul_a = rotl64(t_r, 6'd31);              mul_b = PRIME1; end
      OP_MERGE_C: begin mul_a = h_r ^ t_r;                       mul_b = PRIME1; end
      OP_T8_A:    begin mul_a = buf_r[63:0];                     mul_b = PRIME2; end
      OP_T8_B:    begin mul_a = rotl64(t_r, 6'd31);              mul_b = PRIME1; end
      OP_T8_C:    begin mul_a = rotl64(h_r ^ t_r, 6'd27);        mul_b = PRIME1; end
      OP_T4_A:    begin mul_a = {32'd0, buf_r[31:0]};            mul_b = PRIME1; end
      OP_T4_B:    begin mul_a = rotl64(h_r ^ t_r, 6'd23);        mul_b = PRIME2; end
      OP_T1_A:    begin mul_a = {56'd0, buf_r[7:0]};             mul_b = PRIME5; end
      OP_T1_B:    begin mul_a = rotl64(h_r ^ t_r, 6'd11);        mul_b = PRIME1; end
      OP_AV_A:    begin mul_a = h_r ^ (h_r >> 33);               mul_b = PRIME2; end
      OP_AV_B:    begin mul_a = h_r ^ (h_r >> 29);               mul_b = PRIME3; end
      default:    begin mul_a = h_r;                             mul_b = PRIME1; end
    endcase
  end

  xxh_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  always_comb begin
    seed_cfg_nxt = cfg_wr_en ? cfg_hash_seed : seed_cfg_r;
    seed_nxt     = seed_r;
    for (int k = 0; k < 4; k++) begin
      lane_nxt[k] = lane_r[k];
    end
    buf_nxt   = buf_r;
    fill_nxt  = fill_r;
    len_nxt   = len_r;
    open_nxt  = open_r;
    h_nxt     = h_r;
    t_nxt     = t_r;
    hash_nxt  = hash_r;
    valid_nxt = valid_r && out_stall;
    idx       = 6'd0;

    if (cmd.load) begin
      if (!open_r) begin
        seed_nxt    = seed_cfg_r;
        lane_nxt[0] = seed_cfg_r + PRIME1 + PRIME2;
        lane_nxt[1] = seed_cfg_r + PRIME2;
        lane_nxt[2] = seed_cfg_r;
        lane_nxt[3] = seed_cfg_r - PRIME1;
        open_nxt    = 1'b1;
      end
      for (int p = 0; p < BUF_BYTES; p++) begin
        idx = 6'(p) - base_fill;
        if (idx < {2'd0, cnt_sat}) begin
          buf_nxt[p*8 +: 8] = in_data_word[{idx[2:0], 3'd0} +: 8];
        end
      end
      fill_nxt = base_fill + {2'd0, cnt_sat};
      len_nxt  = base_len + {60'd0, cnt_sat};
    end

    if (cmd.exec) begin
      unique case (cmd.op)
        OP_STRIPE_SHIFT: begin
          buf_nxt  = buf_r >> (STRIPE_BYTES * 8);
          fill_nxt = fill_r - 6'd32;
        end
        OP_FIN_INIT: begin
          h_nxt = (|len_r[63:5]) ? conv : seed_r + PRIME5 + len_r;
        end
        OP_ADD_LEN: h_nxt = h_r + len_r;
        default: h_nxt = h_r;
      endcase
    end

    if (cmd.wb) begin
      unique case (cmd.op)
        OP_ROUND_B: lane_nxt[cmd.lane] = mul_p;
        OP_MERGE_C: h_nxt = mul_p + PRIME4;
        OP_T8_C: begin
          h_nxt    = mul_p + PRIME4;
          buf_nxt  = buf_r >> 64;
          fill_nxt = fill_r - 6'd8;
        end
        OP_T4_B: begin
          h_nxt    = mul_p + PRIME3;
          buf_nxt  = buf_r >> 32;
          fill_nxt = fill_r - 6'd4;
        end
        OP_T1_B: begin
          h_nxt    = mul_p;
          buf_nxt  = buf_r >> 8;
          fill_nxt = fill_r - 6'd1;
        end
        OP_AV_A, OP_AV_B: h_nxt = mul_p;
        default: t_nxt = mul_p;
      endcase
    end

    if (cmd.emit) begin
      hash_nxt  = h_r ^ (h_r >> 32);
      valid_nxt = 1'b1;
      open_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    seed_r <= seed_nxt;
    for (int k = 0; k < 4; k++) begin
      lane_r[k] <= lane_nxt[k];
    end
    buf_r  <= buf_nxt;
    h_r    <= h_nxt;
    t_r    <= t_nxt;
    hash_r <= hash_nxt;
    if (!rst_n) begin
      seed_cfg_r <= 64'd0;
      fill_r     <= 6'd0;
      len_r      <= 64'd0;
      open_r     <= 1'b0;
      valid_r    <= 1'b0;
    end else begin
      seed_cfg_r <= seed_cfg_nxt;
      fill_r     <= fill_nxt;
      len_r      <= len_nxt;
      open_r     <= open_nxt;
      valid_r    <= valid_nxt;
    end
  end

  assign status.stripe_full = (fill_r >= 6'd32);
  assign status.long_msg    = |len_r[63:5];
  assign status.fill_ge8    = (fill_r >= 6'd8);
  assign status.fill_ge4    = (fill_r >= 6'd4);
  assign status.fill_nz     = (fill_r != 6'd0);
  assign status.mul_done    = mul_done;
  assign status.out_free    = !valid_r || !out_stall;

  assign out_valid      = valid_r;
  assign out_hash_value = hash_r;

endmodule

FILE: rtl/core/xxh_ctrl.sv
module xxh_ctrl
  import xxh_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_last_word,
  output logic       in_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_EXEC  = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_WAIT  = 7'b0010000,
    S_TAIL  = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t     state_r, state_nxt;
  dp_op_t     op_r, op_nxt;
  logic [1:0] lane_r, lane_nxt;
  logic       last_r, last_nxt;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    lane_nxt  = lane_r;
    last_nxt  = last_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          last_nxt  = in_last_word;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.stripe_full) begin
          op_nxt    = OP_ROUND_A;
          lane_nxt  = 2'd0;
          state_nxt = S_MUL;
        end else if (last_r) begin
          op_nxt    = OP_FIN_INIT;
          state_nxt = S_EXEC;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EXEC: begin
        unique case (op_r)
          OP_STRIPE_SHIFT: state_nxt = S_CHECK;
          OP_FIN_INIT: begin
            if (status.long_msg) begin
              op_nxt    = OP_MERGE_A;
              lane_nxt  = 2'd0;
              state_nxt = S_MUL;
            end else begin
              state_nxt = S_TAIL;
            end
          end
          default: state_nxt = S_TAIL;
        endcase
      end
      S_MUL: state_nxt = S_WAIT;
      S_WAIT: begin
        if (status.mul_done) begin
          state_nxt = S_MUL;
          unique case (op_r)
            OP_ROUND_A: op_nxt = OP_ROUND_B;
            OP_ROUND_B: begin
              if (lane_r == 2'd3) begin
                op_nxt    = OP_STRIPE_SHIFT;
                state_nxt = S_EXEC;
              end else begin
                op_nxt   = OP_ROUND_A;
                lane_nxt = lane_r + 2'd1;
              end
            end
            OP_MERGE_A: op_nxt = OP_MERGE_B;
            OP_MERGE_B: op_nxt = OP_MERGE_C;
            OP_MERGE_C: begin
              if (lane_r == 2'd3) begin
                op_nxt    = OP_ADD_LEN;
                state_nxt = S_EXEC;
              end else begin
                op_nxt   = OP_MERGE_A;
                lane_nxt = lane_r + 2'd1;
              end
            end
            OP_T8_A: op_nxt = OP_T8_B;
            OP_T8_B: op_nxt = OP_T8_C;
            OP_T4_A: op_nxt = OP_T4_B;
            OP_T1_A: op_nxt = OP_T1_B;
            OP_AV_A: op_nxt = OP_AV_B;
            OP_AV_B: state_nxt = S_EMIT;
            default: state_nxt = S_TAIL;
          endcase
        end
      end
      S_TAIL: begin
        state_nxt = S_MUL;
        priority if (status.fill_ge8) begin
          op_nxt = OP_T8_A;
        end else if (status.fill_ge4) begin
          op_nxt = OP_T4_A;
        end else if (status.fill_nz) begin
          op_nxt = OP_T1_A;
        end else begin
          op_nxt = OP_AV_A;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    lane_r <= lane_nxt;
    last_r <= last_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall      = (state_r != S_IDLE);
  assign cmd.op        = op_r;
  assign cmd.lane      = lane_r;
  assign cmd.load      = (state_r == S_IDLE) && in_valid;
  assign cmd.mul_start = (state_r == S_MUL);
  assign cmd.wb        = (state_r == S_WAIT) && status.mul_done;
  assign cmd.exec      = (state_r == S_EXEC);
  assign cmd.emit      = (state_r == S_EMIT) && status.out_free;

endmodule
